// ----- sv/vwav_pkg.sv -----
// Package for the voxel window axis variance unit.
// Holds sizes, widths, the saturation limit and the shared record types.
// Depends on nothing; used by every other file of the block except the generic RAM.
package vwav_pkg;

  localparam int VOXEL_COUNT = 4096;
  localparam int WINDOW_MAX  = 16;
  localparam int VOX_W       = $clog2(VOXEL_COUNT);
  localparam int SLOT_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
  localparam int HADDR_W     = VOX_W + SLOT_W;
  localparam int HIST_DEPTH  = VOXEL_COUNT * WINDOW_MAX;

  localparam int IDX_W  = 12;
  localparam int AXIS_W = 16;
  localparam int VAR_W  = 30;
  localparam int WL_W   = 5;
  localparam int SUM_W  = AXIS_W + 2;
  localparam int PSUM_W = SUM_W + SLOT_W + 1;
  localparam int SQ_W   = 2 * SUM_W - 1;
  localparam int QSUM_W = SQ_W + SLOT_W + 1;
  localparam int NUM_W  = QSUM_W + CNT_W + 1;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int REM_W  = DEN_W + 1;
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int DSTEP_W   = $clog2(DIV_STEPS + 1);

  localparam logic [WL_W-1:0] WL_RESET = WL_W'(10);
  localparam logic [WL_W-1:0] WL_MIN   = WL_W'(2);
  localparam logic [CNT_W-1:0] WIN_MAX_C = CNT_W'(WINDOW_MAX);
  localparam logic [NUM_W-1:0] VAR_SAT = NUM_W'(805306368);

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [SLOT_W-1:0] oldest;
  } meta_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
  } vec_t;

endpackage

// ----- sv/vwav_if.sv -----
// Channel interfaces of the voxel window axis variance unit.
// Input beat, result beat and configuration write, each with valid and ready.
// Depends on vwav_pkg for field widths.
interface vwav_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [vwav_pkg::IDX_W-1:0]            voxel_index;
  logic signed [vwav_pkg::AXIS_W-1:0]    axis_x;
  logic signed [vwav_pkg::AXIS_W-1:0]    axis_y;
  logic signed [vwav_pkg::AXIS_W-1:0]    axis_z;
  modport source (output valid, voxel_index, axis_x, axis_y, axis_z, input ready);
  modport sink (input valid, voxel_index, axis_x, axis_y, axis_z, output ready);
endinterface

interface vwav_out_if;
  logic                            valid;
  logic                            ready;
  logic [vwav_pkg::VAR_W-1:0]      axis_variance;
  logic [vwav_pkg::CNT_W-1:0]      samples_used;
  logic [vwav_pkg::IDX_W-1:0]      echo_index;
  modport source (output valid, axis_variance, samples_used, echo_index, input ready);
  modport sink (input valid, axis_variance, samples_used, echo_index, output ready);
endinterface

interface vwav_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [vwav_pkg::WL_W-1:0]   window_length;
  modport source (output valid, window_length, input ready);
  modport sink (input valid, window_length, output ready);
endinterface

// ----- sv/vwav_ram.sv -----
// Generic single-port RAM with a registered read.
// Width and depth are parameters; no other dependencies.
module vwav_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/vwav_div.sv -----
// Iterative restoring divider, two quotient bits per cycle.
// Divides the rounded variance numerator by the squared sample count.
// Depends on vwav_pkg.
module vwav_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [vwav_pkg::NUM_W-1:0] num,
  input  logic [vwav_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [vwav_pkg::NUM_W-1:0] quo
);

  typedef struct packed {
    logic [vwav_pkg::REM_W-1:0] rem;
    logic [vwav_pkg::NUM_W-1:0] q;
  } dstate_t;

  function automatic dstate_t div_step(input dstate_t s, input logic [vwav_pkg::DEN_W-1:0] d);
    logic [vwav_pkg::REM_W:0] t;
    dstate_t r;
    t = {s.rem, s.q[vwav_pkg::NUM_W-1]};
    r.q = {s.q[vwav_pkg::NUM_W-2:0], 1'b0};
    if (t >= {2'b00, d}) begin
      t = t - {2'b00, d};
      r.q[0] = 1'b1;
    end
    r.rem = t[vwav_pkg::REM_W-1:0];
    return r;
  endfunction

  dstate_t                     st_r, st_nxt;
  logic [vwav_pkg::DEN_W-1:0]  den_r;
  logic [vwav_pkg::DSTEP_W-1:0] step_r;
  logic                        busy_r, done_r;

  always_comb begin
    st_nxt = div_step(div_step(st_r, den_r), den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= vwav_pkg::DSTEP_W'(vwav_pkg::DIV_STEPS);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == vwav_pkg::DSTEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      st_r.rem <= '0;
      st_r.q   <= num;
      den_r    <= den;
    end else if (busy_r) begin
      st_r <= st_nxt;
    end
  end

  assign done = done_r;
  assign quo  = st_r.q;

endmodule

// ----- sv/voxel_window_axis_variance_unit.sv -----
// Top level: per-voxel sliding-window variance of x+y+z over stored axis vectors.
// Each result comes from a serial ring read of the window's n stored vectors, one vector per
// cycle, then the iterative divider. One item at a time: the next beat is taken only once
// the result of the last one has been loaded into the output register.
// After reset the bookkeeping memory is cleared for all 4096 voxels before the first beat is
// taken; configuration writes are taken at all times. Depends on vwav_pkg, vwav_if, RAM, div.
module voxel_window_axis_variance_unit (
  input  logic         clk,
  input  logic         rst_n,
  vwav_in_if.sink      in_ch,
  vwav_out_if.source   out_ch,
  vwav_cfg_if.sink     cfg_ch
);

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_META = 9'b000000100,
    S_UPD  = 9'b000001000,
    S_RD   = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_SUB  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [vwav_pkg::WL_W-1:0]    wl_r;
  logic [vwav_pkg::VOX_W-1:0]   clr_r;
  logic [vwav_pkg::IDX_W-1:0]   idx_r;
  vwav_pkg::vec_t               vec_r;
  logic [vwav_pkg::CNT_W-1:0]   cnt_r;
  logic [vwav_pkg::SLOT_W-1:0]  old_r, slot_r;
  logic [vwav_pkg::CNT_W-1:0]   k_r;
  logic                         pend_r;
  logic signed [vwav_pkg::PSUM_W-1:0] psum_r;
  logic [vwav_pkg::QSUM_W-1:0]  qsum_r;
  logic [vwav_pkg::NUM_W-1:0]   pa_r, pb_r;
  logic [vwav_pkg::DEN_W-1:0]   den_r;
  logic                         out_valid_r;
  logic [vwav_pkg::VAR_W-1:0]   out_var_r;
  logic [vwav_pkg::CNT_W-1:0]   out_cnt_r;
  logic [vwav_pkg::IDX_W-1:0]   out_idx_r;

  logic [vwav_pkg::VOX_W-1:0]   meta_addr;
  logic                         meta_we;
  vwav_pkg::meta_t              meta_wd, meta_rd;
  logic [vwav_pkg::HADDR_W-1:0] hist_addr;
  logic                         hist_we;
  vwav_pkg::vec_t               hist_rd;

  logic                         in_acc, out_load;
  logic [vwav_pkg::CNT_W-1:0]   len, cnt0, cnt_b;
  logic [vwav_pkg::SLOT_W-1:0]  old_n;
  logic signed [vwav_pkg::SUM_W-1:0] s_val;
  logic signed [2*vwav_pkg::SUM_W-1:0] s_sq;
  logic signed [2*vwav_pkg::PSUM_W-1:0] p_sq;
  logic [vwav_pkg::NUM_W-1:0]   num_val;
  logic                         div_start, div_done;
  logic [vwav_pkg::NUM_W-1:0]   div_quo;

  vwav_ram #(.WIDTH($bits(vwav_pkg::meta_t)), .DEPTH(vwav_pkg::VOXEL_COUNT)) u_meta (
    .clk(clk), .addr(meta_addr), .we(meta_we), .wdata(meta_wd), .rdata(meta_rd)
  );

  vwav_ram #(.WIDTH($bits(vwav_pkg::vec_t)), .DEPTH(vwav_pkg::HIST_DEPTH)) u_hist (
    .clk(clk), .addr(hist_addr), .we(hist_we), .wdata(vec_r), .rdata(hist_rd)
  );

  vwav_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_val), .den(den_r),
    .done(div_done), .quo(div_quo)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_load     = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);
  assign div_start    = (state_r == S_SUB);

  always_comb begin
    len = wl_r;
    if (wl_r < vwav_pkg::WL_MIN) begin
      len = vwav_pkg::WL_MIN;
    end else if (wl_r > vwav_pkg::WIN_MAX_C) begin
      len = vwav_pkg::WIN_MAX_C;
    end
    cnt0 = (meta_rd.cnt > vwav_pkg::WIN_MAX_C) ? vwav_pkg::WIN_MAX_C : meta_rd.cnt;
    old_n = meta_rd.oldest;
    cnt_b = cnt0;
    if (cnt0 >= len) begin
      old_n = meta_rd.oldest + vwav_pkg::SLOT_W'(cnt0 - len + 1'b1);
      cnt_b = len - 1'b1;
    end
  end

  always_comb begin
    meta_we   = (state_r == S_CLR) || (state_r == S_UPD);
    meta_wd   = '0;
    meta_addr = idx_r[vwav_pkg::VOX_W-1:0];
    if (state_r == S_CLR) begin
      meta_addr = clr_r;
    end else if (state_r == S_IDLE) begin
      meta_addr = in_ch.voxel_index[vwav_pkg::VOX_W-1:0];
    end else if (state_r == S_UPD) begin
      meta_wd.cnt    = cnt_r;
      meta_wd.oldest = old_r;
    end
  end

  always_comb begin
    hist_we   = (state_r == S_UPD);
    hist_addr = {idx_r[vwav_pkg::VOX_W-1:0], old_r + k_r[vwav_pkg::SLOT_W-1:0]};
    if (state_r == S_UPD) begin
      hist_addr = {idx_r[vwav_pkg::VOX_W-1:0], slot_r};
    end
  end

  always_comb begin
    s_val = vwav_pkg::SUM_W'(hist_rd.x) + vwav_pkg::SUM_W'(hist_rd.y)
          + vwav_pkg::SUM_W'(hist_rd.z);
    s_sq  = s_val * s_val;
    p_sq  = psum_r * psum_r;
    num_val = (pa_r - pb_r) + vwav_pkg::NUM_W'(den_r >> 1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == vwav_pkg::VOX_W'(vwav_pkg::VOXEL_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_acc) state_nxt = S_META;
      S_META: state_nxt = S_UPD;
      S_UPD:  state_nxt = S_RD;
      S_RD:   if (k_r == cnt_r && !pend_r) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SUB;
      S_SUB:  state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      wl_r        <= vwav_pkg::WL_RESET;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cfg_ch.valid) begin
        wl_r <= cfg_ch.window_length;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_RD) begin
        pend_r <= (k_r != cnt_r);
      end else begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r   <= in_ch.voxel_index;
      vec_r.x <= in_ch.axis_x;
      vec_r.y <= in_ch.axis_y;
      vec_r.z <= in_ch.axis_z;
    end
    if (state_r == S_META) begin
      old_r  <= old_n;
      slot_r <= old_n + cnt_b[vwav_pkg::SLOT_W-1:0];
      cnt_r  <= cnt_b + 1'b1;
    end
    if (state_r == S_UPD) begin
      k_r    <= '0;
      psum_r <= '0;
      qsum_r <= '0;
    end
    if (state_r == S_RD) begin
      if (k_r != cnt_r) begin
        k_r <= k_r + 1'b1;
      end
      if (pend_r) begin
        psum_r <= psum_r + vwav_pkg::PSUM_W'(s_val);
        qsum_r <= qsum_r + vwav_pkg::QSUM_W'(s_sq[vwav_pkg::SQ_W-1:0]);
      end
    end
    if (state_r == S_MUL) begin
      pa_r  <= vwav_pkg::NUM_W'(cnt_r * qsum_r);
      pb_r  <= vwav_pkg::NUM_W'(p_sq[2*vwav_pkg::PSUM_W-2:0]);
      den_r <= vwav_pkg::DEN_W'(cnt_r * cnt_r);
    end
    if (out_load) begin
      out_var_r <= (div_quo > vwav_pkg::VAR_SAT) ? vwav_pkg::VAR_SAT[vwav_pkg::VAR_W-1:0]
                                                 : div_quo[vwav_pkg::VAR_W-1:0];
      out_cnt_r <= cnt_r;
      out_idx_r <= idx_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.axis_variance = out_var_r;
  assign out_ch.samples_used  = out_cnt_r;
  assign out_ch.echo_index    = out_idx_r;

endmodule

// ----- sv/vwav_chk.sv -----
// Port-level checker for the voxel window axis variance unit.
// Watches the result channel; bound to the top level below. Depends on vwav_pkg.
module vwav_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [vwav_pkg::VAR_W-1:0] out_var,
  input logic [vwav_pkg::CNT_W-1:0] out_cnt
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cnt >= vwav_pkg::CNT_W'(1)) && (out_cnt <= vwav_pkg::WIN_MAX_C))
    else $error("sample count out of range");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> vwav_pkg::NUM_W'(out_var) <= vwav_pkg::VAR_SAT)
    else $error("variance above saturation limit");

  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cnt == vwav_pkg::CNT_W'(1) |-> out_var == '0)
    else $error("single-sample window gave nonzero variance");

endmodule

bind voxel_window_axis_variance_unit vwav_chk u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_var(out_ch.axis_variance), .out_cnt(out_ch.samples_used)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for voxel_window_axis_variance_unit: drives axis vectors and
// window-length writes, predicts each spread value in its own window model, checks results.
// Depends on vwav_pkg, vwav_if and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [vwav_pkg::VAR_W-1:0] spread;
    logic [vwav_pkg::CNT_W-1:0] count;
    logic [vwav_pkg::IDX_W-1:0] index;
  } spread_beat_t;

  logic clk;
  logic rst_n;

  vwav_in_if  in_bus ();
  vwav_out_if out_bus ();
  vwav_cfg_if cfg_bus ();

  voxel_window_axis_variance_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  logic [vwav_pkg::AXIS_W-1:0] ring_x [vwav_pkg::HIST_DEPTH];
  logic [vwav_pkg::AXIS_W-1:0] ring_y [vwav_pkg::HIST_DEPTH];
  logic [vwav_pkg::AXIS_W-1:0] ring_z [vwav_pkg::HIST_DEPTH];
  int unsigned                 vox_fill [vwav_pkg::VOXEL_COUNT];
  int unsigned                 vox_oldest [vwav_pkg::VOXEL_COUNT];
  logic [vwav_pkg::WL_W-1:0]   win_len;

  spread_beat_t                pending_spreads[$];
  int unsigned                 mismatches;
  int unsigned                 results_seen;
  int unsigned                 items_sent;
  int unsigned                 tx_idle_pct;
  int unsigned                 rx_idle_pct;
  int unsigned                 rx_hold_req;
  logic [vwav_pkg::IDX_W-1:0]  voxel_pool [8];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic spread_beat_t update_window(logic [vwav_pkg::IDX_W-1:0] idx,
                                                 logic [vwav_pkg::AXIS_W-1:0] ax,
                                                 logic [vwav_pkg::AXIS_W-1:0] ay,
                                                 logic [vwav_pkg::AXIS_W-1:0] az);
    spread_beat_t r;
    int unsigned  v, len, cnt, old, slot, e;
    longint       s, psum, qsum, num, den, res;
    v = idx % vwav_pkg::VOXEL_COUNT;
    len = win_len;
    if (len < 2) len = 2;
    if (len > vwav_pkg::WINDOW_MAX) len = vwav_pkg::WINDOW_MAX;
    cnt = vox_fill[v];
    old = vox_oldest[v];
    if (cnt >= len) begin
      old = (old + cnt - len + 1) % vwav_pkg::WINDOW_MAX;
      cnt = len - 1;
    end
    slot = (old + cnt) % vwav_pkg::WINDOW_MAX;
    ring_x[v * vwav_pkg::WINDOW_MAX + slot] = ax;
    ring_y[v * vwav_pkg::WINDOW_MAX + slot] = ay;
    ring_z[v * vwav_pkg::WINDOW_MAX + slot] = az;
    cnt++;
    vox_fill[v] = cnt;
    vox_oldest[v] = old;
    psum = 0;
    qsum = 0;
    for (int k = 0; k < cnt; k++) begin
      e = v * vwav_pkg::WINDOW_MAX + ((old + k) % vwav_pkg::WINDOW_MAX);
      s = longint'($signed(ring_x[e])) + longint'($signed(ring_y[e]))
        + longint'($signed(ring_z[e]));
      psum += s;
      qsum += s * s;
    end
    num = longint'(cnt) * qsum - psum * psum;
    den = longint'(cnt) * longint'(cnt);
    res = (num + den / 2) / den;
    if (res > 805306368) res = 805306368;
    r.spread = res[vwav_pkg::VAR_W-1:0];
    r.count = cnt[vwav_pkg::CNT_W-1:0];
    r.index = idx;
    return r;
  endfunction

  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      out_bus.ready = 1'b0;
      rx_hold_req = rx_hold_req - 1;
    end else begin
      out_bus.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    spread_beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (pending_spreads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result beat: index %0d spread %0d", out_bus.echo_index,
                   out_bus.axis_variance);
      end else begin
        want = pending_spreads.pop_front();
        if (out_bus.axis_variance !== want.spread || out_bus.samples_used !== want.count ||
            out_bus.echo_index !== want.index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected spread %0d count %0d index %0d, got %0d %0d %0d",
                     want.spread, want.count, want.index, out_bus.axis_variance,
                     out_bus.samples_used, out_bus.echo_index);
        end
      end
    end
  end

  task automatic send_vector(logic [vwav_pkg::IDX_W-1:0] idx, logic [vwav_pkg::AXIS_W-1:0] ax,
                             logic [vwav_pkg::AXIS_W-1:0] ay, logic [vwav_pkg::AXIS_W-1:0] az);
    spread_beat_t exp_beat;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.voxel_index = idx;
    in_bus.axis_x = ax;
    in_bus.axis_y = ay;
    in_bus.axis_z = az;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    exp_beat = update_window(idx, ax, ay, az);
    pending_spreads.insert(pending_spreads.size(), exp_beat);
    items_sent++;
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_spreads.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_window_length(logic [vwav_pkg::WL_W-1:0] wl);
    drain_results();
    cfg_bus.valid = 1'b1;
    cfg_bus.window_length = wl;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    win_len = wl;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  function automatic logic [vwav_pkg::AXIS_W-1:0] rand_axis();
    if ($urandom_range(9) == 0) return vwav_pkg::AXIS_W'($urandom);
    return vwav_pkg::AXIS_W'($urandom_range(32768) - 16384);
  endfunction

  task automatic test_directed_extremes();
    send_vector(12'd0, 16'sd16384, 16'sd16384, 16'sd16384);
    send_vector(12'd0, -16'sd16384, -16'sd16384, -16'sd16384);
    send_vector(12'd0, 16'sd16384, -16'sd16384, 16'sd0);
    send_vector(12'd4095, 16'h7fff, 16'h7fff, 16'h7fff);
    send_vector(12'd4095, 16'h8000, 16'h8000, 16'h8000);
    send_vector(12'd4095, 16'h7fff, 16'h7fff, 16'h7fff);
    send_vector(12'hAAA, 16'h5555, 16'hAAAA, 16'h0000);
    send_vector(12'h555, 16'hFFFF, 16'h0001, 16'hFFFF);
  endtask

  task automatic test_window_settings();
    write_window_length(5'd2);
    for (int i = 0; i < 3; i++) send_vector(12'd7, rand_axis(), rand_axis(), rand_axis());
    write_window_length(5'd0);
    send_vector(12'd7, 16'sd1000, 16'sd0, 16'sd0);
    write_window_length(5'd1);
    send_vector(12'd7, -16'sd1000, 16'sd0, 16'sd0);
    write_window_length(5'd31);
    for (int i = 0; i < 6; i++) send_vector(12'd9, rand_axis(), rand_axis(), rand_axis());
    write_window_length(5'd3);
    send_vector(12'd9, rand_axis(), rand_axis(), rand_axis());
    write_window_length(5'd16);
  endtask

  task automatic run_random(int unsigned n);
    logic [vwav_pkg::IDX_W-1:0] idx;
    for (int i = 0; i < n; i++) begin
      if (i % 70 == 69) write_window_length(vwav_pkg::WL_W'($urandom));
      if ($urandom_range(9) < 8) idx = voxel_pool[$urandom_range(7)];
      else idx = vwav_pkg::IDX_W'($urandom);
      send_vector(idx, rand_axis(), rand_axis(), rand_axis());
    end
  endtask

  task automatic test_random_idling();
    for (int i = 0; i < 8; i++) begin
      voxel_pool[i] = vwav_pkg::IDX_W'($urandom_range(vwav_pkg::VOXEL_COUNT - 1));
    end
    tx_idle_pct = 6;
    rx_idle_pct = 63;
    run_random(380);
    tx_idle_pct = 63;
    rx_idle_pct = 6;
    run_random(380);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(380);
  endtask

  task automatic test_backpressure();
    rx_hold_req = 400;
    for (int i = 0; i < 20; i++) send_vector(voxel_pool[i % 2], rand_axis(), rand_axis(),
                                             rand_axis());
    while (pending_spreads.size() != 0) @(negedge clk);
    for (int i = 0; i < 10; i++) send_vector(voxel_pool[0], rand_axis(), rand_axis(),
                                             rand_axis());
  endtask

  initial begin
    for (int i = 0; i < vwav_pkg::VOXEL_COUNT; i++) begin
      vox_fill[i] = 0;
      vox_oldest[i] = 0;
    end
    win_len = vwav_pkg::WL_RESET;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.voxel_index = '0;
    in_bus.axis_x = '0;
    in_bus.axis_y = '0;
    in_bus.axis_z = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.window_length = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_directed_extremes();
    test_window_settings();
    test_random_idling();
    test_backpressure();
    drain_results();
    $display("Sent %0d vectors, checked %0d results over window lengths 0 to 31,", items_sent,
             results_seen);
    $display("with idling on both sides, a long output stall and a mid-run window shrink.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
